### design/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and codes for the rotating server dispatcher
// Holds the field widths, the opcode and result kind codes and the sequencer
// state type.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int unsigned TIME_W  = 31;
  localparam int unsigned END_W   = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned ID_W    = 6;
  localparam int unsigned NUM_W   = 7;

  localparam logic OP_SUBMIT     = 1'b0;
  localparam logic OP_REPORT     = 1'b1;
  localparam logic KIND_DISPATCH = 1'b0;
  localparam logic KIND_REPORT   = 1'b1;

  localparam logic [NUM_W-1:0] NUM_RESET = 7'd16;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_DRD,
    ST_DCHK,
    ST_RRD,
    ST_RMAX,
    ST_ERD,
    ST_EMIT
  } rsd_state_e;

endpackage

### design/rsd_req_if.sv
// ----------------------------------------------------------------------------
// rsd_req_if: request channel
// Valid/ready channel carrying one dispatch or report request item.
// ----------------------------------------------------------------------------
interface rsd_req_if import rsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [TIME_W-1:0] arrival_time;
  logic [TIME_W-1:0] duration;

  modport source (output valid, output opcode, output arrival_time, output duration,
                  input ready);
  modport sink   (input valid, input opcode, input arrival_time, input duration,
                  output ready);
endinterface

### design/rsd_res_if.sv
// ----------------------------------------------------------------------------
// rsd_res_if: result channel
// Valid/ready channel carrying one dispatch result or report entry item.
// ----------------------------------------------------------------------------
interface rsd_res_if import rsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic             accepted;
  logic [ID_W-1:0]  server_id;
  logic [CNT_W-1:0] served_total;
  logic             last;

  modport source (output valid, output kind, output accepted, output server_id,
                  output served_total, output last, input ready);
  modport sink   (input valid, input kind, input accepted, input server_id,
                  input served_total, input last, output ready);
endinterface

### design/rotating_server_dispatcher.sv
// ----------------------------------------------------------------------------
// rotating_server_dispatcher: first-free server dispatch with busiest report
// Hands timed requests to a pool of servers, searching from a rotating
// preferred index, and reports the servers with the highest served count.
// ----------------------------------------------------------------------------
// Usage:
//   req_i takes one item at a time (valid/ready). opcode 0 submits a request
//   with arrival_time and duration, opcode 1 asks for the busiest-server
//   report. res_o gives one result item per request, or one item per busiest
//   server for a report, with last set on the final one.
//   cfg_we_i/cfg_wdata_i write num_servers (0 acts as 1, values above SERVERS
//   act as SERVERS); write it only while the block is idle.
// Timing:
//   end times and served counts sit in two single-port memories with a
//   registered read, so every server visit takes a read state and a check state.
//   A request first brings the preferred index below the server count by
//   repeated subtraction (no subtract steps unless the count was lowered),
//   then visits servers from there (1 to k of them) until one is free.
//   A report runs a max pass then an output pass.
//   req_i is ready only in the idle state; the output register lets the next
//   item be taken while the last result still waits on res_o.
// Reset:
//   every server free with zero count (per-entry valid bits), preferred index
//   0, num_servers 16. A stalled res_o holds the sequencer until it drains.
// ----------------------------------------------------------------------------
module rotating_server_dispatcher
  import rsd_pkg::*;
#(
  parameter int unsigned SERVERS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [NUM_W-1:0]  cfg_wdata_i,
  rsd_req_if.sink           req_i,
  rsd_res_if.source         res_o
);

  localparam int unsigned AW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam logic [NUM_W-1:0] SRV_N = NUM_W'(SERVERS);

  // storage
  logic [END_W-1:0] et_mem [SERVERS];
  logic [CNT_W-1:0] sc_mem [SERVERS];
  logic [SERVERS-1:0] vld_q;
  logic [END_W-1:0] et_rd_q;
  logic [CNT_W-1:0] sc_rd_q;
  logic             vld_rd_q;

  rsd_state_e state_q, state_d;
  logic [NUM_W-1:0]  num_q;
  logic [NUM_W-1:0]  k;
  logic [ID_W-1:0]   ri_q, ri_d;
  logic [ID_W-1:0]   pref_q, pref_d;
  logic [ID_W-1:0]   pos_q, pos_d;
  logic [NUM_W-1:0]  step_q, step_d;
  logic [TIME_W-1:0] arrive_q, arrive_d;
  logic [END_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  best_q, best_d;
  logic [ID_W-1:0]   lastid_q, lastid_d;

  logic             rv_q, rv_d;
  logic             rkind_q, rkind_d;
  logic             racc_q, racc_d;
  logic [ID_W-1:0]  rid_q, rid_d;
  logic [CNT_W-1:0] rtot_q, rtot_d;
  logic             rlast_q, rlast_d;

  logic             out_free;
  logic             wr_en;
  logic [END_W-1:0] end_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] cnt_inc;
  logic [NUM_W-1:0] pos_nx;
  logic [NUM_W-1:0] pref_ext;
  logic [AW-1:0]    addr;

  always_comb begin
    if (num_q == '0) begin
      k = NUM_W'(1);
    end else if (num_q > SRV_N) begin
      k = SRV_N;
    end else begin
      k = num_q;
    end
  end

  assign addr     = pos_q[AW-1:0];
  assign end_eff  = vld_rd_q ? et_rd_q : '0;
  assign cnt_eff  = vld_rd_q ? sc_rd_q : '0;
  assign cnt_inc  = (cnt_eff == CNT_MAX) ? cnt_eff : cnt_eff + CNT_W'(1);
  assign pos_nx   = {1'b0, pos_q} + NUM_W'(1);
  assign pref_ext = {1'b0, pref_q};
  assign out_free = !rv_q || res_o.ready;

  assign req_i.ready        = (state_q == ST_IDLE);
  assign res_o.valid        = rv_q;
  assign res_o.kind         = rkind_q;
  assign res_o.accepted     = racc_q;
  assign res_o.server_id    = rid_q;
  assign res_o.served_total = rtot_q;
  assign res_o.last         = rlast_q;

  always_comb begin
    state_d  = state_q;
    ri_d     = ri_q;
    pref_d   = pref_q;
    pos_d    = pos_q;
    step_d   = step_q;
    arrive_d = arrive_q;
    sum_d    = sum_q;
    best_d   = best_q;
    lastid_d = lastid_q;
    rv_d     = rv_q && !res_o.ready;
    rkind_d  = rkind_q;
    racc_d   = racc_q;
    rid_d    = rid_q;
    rtot_d   = rtot_q;
    rlast_d  = rlast_q;
    wr_en    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          arrive_d = req_i.arrival_time;
          sum_d    = {1'b0, req_i.arrival_time} + {1'b0, req_i.duration};
          best_d   = '0;
          lastid_d = '0;
          if (req_i.opcode == OP_REPORT) begin
            pos_d   = '0;
            state_d = ST_RRD;
          end else begin
            pref_d  = ri_q;
            state_d = ST_MOD;
          end
        end
      end
      // preferred index modulo the server count, one subtract a cycle
      ST_MOD: begin
        if (pref_ext >= k) begin
          pref_d = ID_W'(pref_ext - k);
        end else begin
          ri_d    = (pref_ext + NUM_W'(1) == k) ? '0 : ID_W'(pref_ext + NUM_W'(1));
          pos_d   = pref_q;
          step_d  = '0;
          state_d = ST_DRD;
        end
      end
      ST_DRD: begin
        state_d = ST_DCHK;
      end
      ST_DCHK: begin
        if (end_eff <= {1'b0, arrive_q}) begin
          if (out_free) begin
            wr_en   = 1'b1;
            rv_d    = 1'b1;
            rkind_d = KIND_DISPATCH;
            racc_d  = 1'b1;
            rid_d   = pos_q;
            rtot_d  = cnt_inc;
            rlast_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (step_q + NUM_W'(1) == k) begin
          // every server busy: drop
          if (out_free) begin
            rv_d    = 1'b1;
            rkind_d = KIND_DISPATCH;
            racc_d  = 1'b0;
            rid_d   = '0;
            rtot_d  = '0;
            rlast_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          step_d  = step_q + NUM_W'(1);
          pos_d   = (pos_nx == k) ? '0 : ID_W'(pos_nx);
          state_d = ST_DRD;
        end
      end
      ST_RRD: begin
        state_d = ST_RMAX;
      end
      // max pass, remembering the highest index holding the max
      ST_RMAX: begin
        if (cnt_eff >= best_q) begin
          best_d   = cnt_eff;
          lastid_d = pos_q;
        end
        if (pos_nx == k) begin
          pos_d   = '0;
          state_d = ST_ERD;
        end else begin
          pos_d   = ID_W'(pos_nx);
          state_d = ST_RRD;
        end
      end
      ST_ERD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cnt_eff == best_q) begin
          if (out_free) begin
            rv_d    = 1'b1;
            rkind_d = KIND_REPORT;
            racc_d  = 1'b0;
            rid_d   = pos_q;
            rtot_d  = best_q;
            rlast_d = (pos_q == lastid_q);
            if (pos_q == lastid_q) begin
              state_d = ST_IDLE;
            end else begin
              pos_d   = ID_W'(pos_nx);
              state_d = ST_ERD;
            end
          end
        end else begin
          pos_d   = ID_W'(pos_nx);
          state_d = ST_ERD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      num_q   <= NUM_RESET;
      ri_q    <= '0;
      rv_q    <= 1'b0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      ri_q    <= ri_d;
      rv_q    <= rv_d;
      if (cfg_we_i) begin
        num_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        vld_q[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pref_q   <= pref_d;
    pos_q    <= pos_d;
    step_q   <= step_d;
    arrive_q <= arrive_d;
    sum_q    <= sum_d;
    best_q   <= best_d;
    lastid_q <= lastid_d;
    rkind_q  <= rkind_d;
    racc_q   <= racc_d;
    rid_q    <= rid_d;
    rtot_q   <= rtot_d;
    rlast_q  <= rlast_d;
    vld_rd_q <= vld_q[addr];
  end

  // server memories, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      et_mem[addr] <= sum_q;
      sc_mem[addr] <= cnt_inc;
    end
    et_rd_q <= et_mem[addr];
    sc_rd_q <= sc_mem[addr];
  end

  a_dispatch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && rkind_q == KIND_DISPATCH) |-> rlast_q)
    else $error("dispatch result without last");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && rkind_q == KIND_DISPATCH && !racc_q) |-> (rid_q == '0 && rtot_q == '0))
    else $error("dropped request with nonzero payload");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ({1'b0, pos_q} < k))
    else $error("write to a server outside the active pool");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DCHK) |-> ({1'b0, pos_q} < k && step_q < k))
    else $error("dispatch scan beyond the server count");

  a_report_last_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && pos_q == lastid_q) |-> (cnt_eff == best_q))
    else $error("report last index does not hold the max count");

endmodule
